// ===== hw/rtl/cktc_pkg.sv =====
// Package with shared types, constants and lookup functions of the clock tree checker.
`timescale 1ns / 1ps
package cktc_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ARG = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [1:0] CSRC_INT  = 2'd0;
    localparam logic [1:0] CSRC_XTAL = 2'd1;
    localparam logic [1:0] CSRC_PLL  = 2'd2;

    localparam logic [31:0] INTERNAL_HZ = 32'd16000000;
    localparam logic [31:0] SYSCLK_MAX  = 32'd168000000;
    localparam logic [31:0] PCLK1_MAX   = 32'd42000000;
    localparam logic [31:0] PCLK2_MAX   = 32'd84000000;
    localparam logic [31:0] XTAL_MIN    = 32'd4000000;
    localparam logic [31:0] XTAL_MAX    = 32'd26000000;
    localparam logic [31:0] PLLIN_MIN   = 32'd1000000;
    localparam logic [31:0] PLLIN_MAX   = 32'd2000000;
    localparam logic [40:0] VCO_MIN     = 41'd100000000;
    localparam logic [40:0] VCO_MAX     = 41'd432000000;

    localparam int IN_W  = 80;
    localparam int OUT_W = 112;

    // Divider quotient stage count; the width of the quotients sets it.
    localparam int DIV_W = 41;

    // Members run from the highest bits down, so csrc lands in the lowest bits
    // and the layout matches the input tdata.
    typedef struct packed {
        logic [3:0]  ws;
        logic [2:0]  apb2;
        logic [2:0]  apb1;
        logic [3:0]  ahb;
        logic [3:0]  q;
        logic [3:0]  p;
        logic [8:0]  n;
        logic [7:0]  m;
        logic [31:0] xtal;
        logic [1:0]  psrc;
        logic [1:0]  csrc;
    } cfg_t;

    // log2 of the AHB divider.
    function automatic logic [3:0] ahb_shift(input logic [3:0] code);
        logic [3:0] s;
        case (code)
            4'd8:    s = 4'd1;
            4'd9:    s = 4'd2;
            4'd10:   s = 4'd3;
            4'd11:   s = 4'd4;
            4'd12:   s = 4'd6;
            4'd13:   s = 4'd7;
            4'd14:   s = 4'd8;
            4'd15:   s = 4'd9;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] apb_shift(input logic [2:0] code);
        return code[2] ? {1'b0, code[1:0]} + 3'd1 : 3'd0;
    endfunction

    function automatic logic [2:0] latency_needed(input logic [31:0] h);
        logic [2:0] l;
        if (h > 32'd150000000)      l = 3'd5;
        else if (h > 32'd120000000) l = 3'd4;
        else if (h > 32'd90000000)  l = 3'd3;
        else if (h > 32'd60000000)  l = 3'd2;
        else if (h > 32'd30000000)  l = 3'd1;
        else                        l = 3'd0;
        return l;
    endfunction

endpackage

// ===== hw/rtl/clock_tree_config_checker.sv =====
// Top level of the clock tree configuration checker.
`timescale 1ns / 1ps
//
//  Channel | Direction | Transaction content
//  s_axis  | in        | one proposed clock-tree setting
//  m_axis  | out       | status and resulting clock rates
//
//  One setting enters per cycle unless the output register holds an untaken result.
//  Each setting passes the stage 1 register, two bit-per-stage dividers in series
//  (src * N by M, then VCO by P), the stage 3 register and the output register. The
//  whole pipeline advances together: on an untaken output every stage freezes, so nothing
//  is lost or repeated. Reset clears only the valid bits. Non-ok results carry zero rates.
module clock_tree_config_checker
    import cktc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: clock_source[1:0], pll_source[3:2], crystal_hz[35:4], pll_m[43:36],
    // pll_n[52:44], pll_p[56:53], pll_q[60:57], ahb_code[64:61], apb1_code[67:65],
    // apb2_code[70:68], wait_states[74:71], zeros above.
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // tdata: status[1:0], sysclk_hz[29:2], hclk_hz[57:30], pclk1_hz[83:58],
    // pclk2_hz[110:84], zero above.
    output logic [OUT_W-1:0] m_axis_tdata
);
    // Side payload carried through the dividers.
    typedef struct packed {
        logic [1:0]  st;      // status decided so far (ok means continue)
        logic        pll;     // sysclk comes from the PLL
        logic [31:0] src;     // direct sysclk, or PLL input source
        logic [3:0]  p;
        logic [3:0]  ahb;
        logic [2:0]  apb1;
        logic [2:0]  apb2;
        logic [3:0]  ws;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    logic en;
    logic out_vld_reg;
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 0: decode, argument checks and crystal range checks.
    cfg_t  c;
    side_t s0_next;
    logic [40:0] prod_next;
    assign c = cfg_t'({s_axis_tdata[74:71], s_axis_tdata[70:68], s_axis_tdata[67:65],
                       s_axis_tdata[64:61], s_axis_tdata[60:57], s_axis_tdata[56:53],
                       s_axis_tdata[52:44], s_axis_tdata[43:36], s_axis_tdata[35:4],
                       s_axis_tdata[3:2], s_axis_tdata[1:0]});

    always_comb
    begin
        logic ahb_ok, apb1_ok, apb2_ok, xbad;
        logic [31:0] psrc_hz;
        ahb_ok  = (c.ahb == 4'd0) || c.ahb[3];
        apb1_ok = (c.apb1 == 3'd0) || c.apb1[2];
        apb2_ok = (c.apb2 == 3'd0) || c.apb2[2];
        xbad    = (c.xtal < XTAL_MIN) || (c.xtal > XTAL_MAX);
        psrc_hz = c.psrc[0] ? c.xtal : INTERNAL_HZ;
        s0_next      = '0;
        s0_next.p    = c.p;
        s0_next.ahb  = c.ahb;
        s0_next.apb1 = c.apb1;
        s0_next.apb2 = c.apb2;
        s0_next.ws   = c.ws;
        s0_next.st   = ST_OK;
        s0_next.src  = INTERNAL_HZ;
        if (!ahb_ok || !apb1_ok || !apb2_ok || c.ws > 4'd7)
        begin
            s0_next.st = ST_BAD_ARG;
        end
        else
        begin
            case (c.csrc)
                CSRC_INT:  s0_next.src = INTERNAL_HZ;
                CSRC_XTAL:
                begin
                    s0_next.src = c.xtal;
                    if (xbad) s0_next.st = ST_RANGE;
                end
                CSRC_PLL:
                begin
                    s0_next.pll = 1'b1;
                    s0_next.src = psrc_hz;
                    if (c.psrc[1]) s0_next.st = ST_BAD_ARG;
                    else if (c.psrc[0] && xbad) s0_next.st = ST_RANGE;
                    else if (psrc_hz == 32'd0 || c.m < 8'd2 || c.m > 8'd63
                             || c.n < 9'd50 || c.n > 9'd432 || c.q < 4'd2
                             || !(c.p == 4'd2 || c.p == 4'd4 || c.p == 4'd6
                                  || c.p == 4'd8))
                        s0_next.st = ST_BAD_ARG;
                end
                default: s0_next.st = ST_BAD_ARG;
            endcase
        end
        prod_next = 41'(psrc_hz) * 41'(c.n);
    end

    // Stage 1 register: product and M.
    logic        s1_vld_reg;
    side_t       s1_side_reg;
    logic [40:0] s1_prod_reg;
    logic [7:0]  s1_m_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_vld_reg <= 1'b0;
        else if (en) s1_vld_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s0_next;
            s1_prod_reg <= prod_next;
            s1_m_reg    <= s0_next.pll ? c.m : 8'd1;
        end
    end

    // VCO = src * N / M. The PLL input src / M is also needed: since
    // floor(src*N/M) limits alone do not give it, divide src by M in a side lane.
    logic        d1_vld;
    logic [40:0] vco;
    side_t       d1_side;
    logic [40:0] pin_q;
    logic        d1b_vld;
    logic [SIDE_W-1:0] d1b_side_unused;

    cktc_div_pipe #(.NUM_W(DIV_W), .DEN_W(8), .SIDE_W(SIDE_W)) u_div_vco (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s1_vld_reg),
        .num(s1_prod_reg), .den(s1_m_reg), .side_in(s1_side_reg),
        .out_valid(d1_vld), .quo(vco), .side_out(d1_side)
    );
    cktc_div_pipe #(.NUM_W(DIV_W), .DEN_W(8), .SIDE_W(SIDE_W)) u_div_pin (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s1_vld_reg),
        .num(41'(s1_side_reg.src)), .den(s1_m_reg), .side_in(s1_side_reg),
        .out_valid(d1b_vld), .quo(pin_q), .side_out(d1b_side_unused)
    );

    // Stage 2: PLL range checks, then divide VCO by P (a direct source by one).
    side_t s2_next;
    always_comb
    begin
        s2_next = d1_side;
        if (d1_side.pll && d1_side.st == ST_OK)
        begin
            if (pin_q < 41'(PLLIN_MIN) || pin_q > 41'(PLLIN_MAX)
                || vco < VCO_MIN || vco > VCO_MAX)
                s2_next.st = ST_RANGE;
        end
    end

    logic        d2_vld;
    logic [40:0] sys_q;
    side_t       d2_side;
    cktc_div_pipe #(.NUM_W(DIV_W), .DEN_W(4), .SIDE_W(SIDE_W)) u_div_p (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d1_vld && d1b_vld),
        .num(d1_side.pll ? vco : 41'(d1_side.src)),
        .den(d1_side.pll ? d1_side.p : 4'd1),
        .side_in(s2_next),
        .out_valid(d2_vld), .quo(sys_q), .side_out(d2_side)
    );

    // Stage 3: AHB prescaler (shift) registered; the APB shifts follow combinationally.
    logic        s3_vld_reg;
    side_t       s3_side_reg;
    logic [31:0] s3_sys_reg, s3_h_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s3_vld_reg <= 1'b0;
        else if (en) s3_vld_reg <= d2_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= d2_side;
            s3_sys_reg  <= sys_q[31:0];
            s3_h_reg    <= sys_q[31:0] >> ahb_shift(d2_side.ahb);
        end
    end

    // Final limits and output register.
    logic [31:0] c1, c2;
    logic [1:0]  st_fin;
    assign c1 = s3_h_reg >> apb_shift(s3_side_reg.apb1);
    assign c2 = s3_h_reg >> apb_shift(s3_side_reg.apb2);
    always_comb
    begin
        st_fin = s3_side_reg.st;
        if (st_fin == ST_OK &&
            (s3_sys_reg > SYSCLK_MAX || s3_h_reg > SYSCLK_MAX || c1 > PCLK1_MAX
             || c2 > PCLK2_MAX
             || {1'b0, s3_side_reg.ws} < {2'b00, latency_needed(s3_h_reg)}))
            st_fin = ST_RANGE;
    end

    logic [OUT_W-1:0] out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_vld_reg <= 1'b0;
        else if (en) out_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (st_fin == ST_OK)
                out_data_reg <= {1'b0, c2[26:0], c1[25:0], s3_h_reg[27:0],
                                 s3_sys_reg[27:0], st_fin};
            else
                out_data_reg <= {110'd0, st_fin};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule

// ===== hw/rtl/cktc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps
module cktc_div_pipe #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 8,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);
    // Entry i holds the output of stage i.
    logic                 vld_reg [NUM_W];
    logic [NUM_W-1:0]     q_reg   [NUM_W];
    logic [DEN_W-1:0]     rem_reg [NUM_W];
    logic [NUM_W-1:0]     num_reg [NUM_W];
    logic [DEN_W-1:0]     den_reg [NUM_W];
    logic [SIDE_W-1:0]    side_reg[NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic              v_in;
        logic [NUM_W-1:0]  q_in;
        logic [DEN_W-1:0]  r_in;
        logic [NUM_W-1:0]  n_in;
        logic [DEN_W-1:0]  d_in;
        logic [SIDE_W-1:0] sd_in;
        logic [DEN_W:0]    trial;
        logic              ge;

        if (i == 0) begin : g_head
            assign v_in  = in_valid;
            assign q_in  = '0;
            assign r_in  = '0;
            assign n_in  = num;
            assign d_in  = den;
            assign sd_in = side_in;
        end else begin : g_link
            assign v_in  = vld_reg[i-1];
            assign q_in  = q_reg[i-1];
            assign r_in  = rem_reg[i-1];
            assign n_in  = num_reg[i-1];
            assign d_in  = den_reg[i-1];
            assign sd_in = side_reg[i-1];
        end

        assign trial = {r_in, n_in[NUM_W-1-i]};
        assign ge    = trial >= {1'b0, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i]    <= {q_in[NUM_W-2:0], ge};
                rem_reg[i]  <= ge ? DEN_W'(trial - {1'b0, d_in})
                                  : trial[DEN_W-1:0];
                num_reg[i]  <= n_in;
                den_reg[i]  <= d_in;
                side_reg[i] <= sd_in;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quo       = q_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];
endmodule

// ===== verif/clock_tree_config_checker_scoreboard.sv =====
// Checker that predicts and compares every clock-tree verdict leaving the block.
`timescale 1ns / 1ps
module clock_tree_config_checker_scoreboard
    import cktc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [OUT_W-1:0]  m_axis_tdata,
    output int                mismatches,
    output int                pending,
    output int                verdicts_seen
);

    // Highest field first, so status sits in the lowest bits as on the bus.
    typedef struct packed {
        logic [26:0] pclk2;
        logic [25:0] pclk1;
        logic [27:0] hclk;
        logic [27:0] sysclk;
        logic [1:0]  status;
    } verdict_t;

    verdict_t verdict_q[$];

    function automatic int unsigned ahb_divisor(input logic [3:0] code);
        int unsigned d;
        case (code)
            4'd8:    d = 2;
            4'd9:    d = 4;
            4'd10:   d = 8;
            4'd11:   d = 16;
            4'd12:   d = 64;
            4'd13:   d = 128;
            4'd14:   d = 256;
            4'd15:   d = 512;
            default: d = 1;
        endcase
        return d;
    endfunction

    function automatic int unsigned apb_divisor(input logic [2:0] code);
        return (code < 3'd4) ? 1 : (1 << (code - 3'd3));
    endfunction

    function automatic int unsigned wait_needed(input longint unsigned h);
        if (h > 150000000) return 5;
        if (h > 120000000) return 4;
        if (h > 90000000) return 3;
        if (h > 60000000) return 2;
        if (h > 30000000) return 1;
        return 0;
    endfunction

    function automatic logic [1:0] judge_setting(input cfg_t c, output longint unsigned sys,
                                                 output longint unsigned h,
                                                 output longint unsigned p1,
                                                 output longint unsigned p2);
        longint unsigned src;
        longint unsigned pin;
        longint unsigned vco;
        logic xtal_bad;
        sys = 0; h = 0; p1 = 0; p2 = 0;
        xtal_bad = (c.xtal < XTAL_MIN) || (c.xtal > XTAL_MAX);
        if (!(c.ahb == 0 || c.ahb >= 8) || !(c.apb1 == 0 || c.apb1 >= 4) ||
            !(c.apb2 == 0 || c.apb2 >= 4) || c.ws > 7)
            return ST_BAD_ARG;
        if (c.csrc == CSRC_INT) begin
            src = INTERNAL_HZ;
        end else if (c.csrc == CSRC_XTAL) begin
            src = c.xtal;
            if (xtal_bad) return ST_RANGE;
        end else if (c.csrc == CSRC_PLL) begin
            if (c.psrc > 1) return ST_BAD_ARG;
            src = (c.psrc == 1) ? c.xtal : INTERNAL_HZ;
            if (c.psrc == 1 && xtal_bad) return ST_RANGE;
            if (src == 0 || c.m < 2 || c.m > 63 || c.n < 50 || c.n > 432 || c.q < 2 ||
                !(c.p == 2 || c.p == 4 || c.p == 6 || c.p == 8))
                return ST_BAD_ARG;
            pin = src / c.m;
            vco = (src * c.n) / c.m;
            if (pin < PLLIN_MIN || pin > PLLIN_MAX || vco < VCO_MIN || vco > VCO_MAX)
                return ST_RANGE;
            src = vco / c.p;
        end else begin
            return ST_BAD_ARG;
        end
        h = src / ahb_divisor(c.ahb);
        p1 = h / apb_divisor(c.apb1);
        p2 = h / apb_divisor(c.apb2);
        sys = src;
        if (src > SYSCLK_MAX || h > SYSCLK_MAX || p1 > PCLK1_MAX || p2 > PCLK2_MAX ||
            c.ws < wait_needed(h)) begin
            sys = 0; h = 0; p1 = 0; p2 = 0;
            return ST_RANGE;
        end
        return ST_OK;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    assign pending = verdict_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t  want;
        verdict_t  got;
        longint unsigned sys, h, p1, p2;
        if (!rst_n) begin
            mismatches    <= 0;
            verdicts_seen <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                want.status = judge_setting(cfg_t'(s_axis_tdata[74:0]), sys, h, p1, p2);
                want.sysclk = sys[27:0];
                want.hclk   = h[27:0];
                want.pclk1  = p1[25:0];
                want.pclk2  = p2[26:0];
                verdict_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                verdicts_seen <= verdicts_seen + 1;
                got = verdict_t'(m_axis_tdata[110:0]);
                if (verdict_q.size() == 0) begin
                    $display("ERROR at %0t: result with no pending setting", $realtime);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.sysclk != want.sysclk)
                        report_mismatch("sysclk_hz", got.sysclk, want.sysclk);
                    if (got.hclk != want.hclk)
                        report_mismatch("hclk_hz", got.hclk, want.hclk);
                    if (got.pclk1 != want.pclk1)
                        report_mismatch("pclk1_hz", got.pclk1, want.pclk1);
                    if (got.pclk2 != want.pclk2)
                        report_mismatch("pclk2_hz", got.pclk2, want.pclk2);
                end
            end
        end
    end

endmodule

// ===== verif/clock_tree_config_checker_tb.sv =====
// Testbench top that drives clock-tree settings into the checker block and gives the verdict.
`timescale 1ns / 1ps
module clock_tree_config_checker_tb;
    import cktc_pkg::*;

    // The random part is this many settings; the directed part comes first.
    localparam int RANDOM_ITEMS = 1800;
    // No acceptance on either channel for this long means the block hung.
    localparam int STALL_LIMIT = 5000;
    // Pipeline depth of the block plus some margin, waited out at the end.
    localparam int DRAIN_CYCLES = 2 * DIV_W + 20;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;
    int verdicts_seen;
    int idle_cycles;
    // Random gaps are allowed while this is set; the tail of the run goes without them.
    bit allow_gaps;
    int status_count[3];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    clock_tree_config_checker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    clock_tree_config_checker_scoreboard i_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .verdicts_seen (verdicts_seen)
    );

    // Tally of statuses seen, used only for the closing summary.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready && m_axis_tdata[1:0] <= ST_RANGE)
            status_count[m_axis_tdata[1:0]]++;
    end

    // Receiver side: ready drops for random bursts while gaps are allowed.
    initial
    begin
        int hold;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else if (allow_gaps && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 13) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // The watchdog restarts its count whenever either channel completes a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("clock_tree_config_checker: mismatch");
            $finish;
        end
    end

    // Offers one setting, holding it until the block takes it, after an optional gap.
    task automatic send_setting(input cfg_t c);
        int gap;
        if (allow_gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_W'(c);
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // A setting drawn across the whole field space, every bit reachable.
    function automatic cfg_t any_setting();
        cfg_t c;
        c.csrc = 2'($urandom); c.psrc = 2'($urandom); c.xtal = $urandom;
        c.m    = 8'($urandom); c.n    = 9'($urandom); c.p    = 4'($urandom);
        c.q    = 4'($urandom); c.ahb  = 4'($urandom); c.apb1 = 3'($urandom);
        c.apb2 = 3'($urandom); c.ws   = 4'($urandom);
        return c;
    endfunction

    // A mostly legal setting with random content, so the later checks are reached.
    function automatic cfg_t plausible_setting();
        cfg_t c;
        int unsigned sel;
        c.csrc = ($urandom_range(0, 9) < 6) ? CSRC_PLL : 2'($urandom_range(0, 1));
        c.psrc = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
        c.xtal = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30000000)
                                              : $urandom_range(4000000, 26000000);
        c.m    = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(2, 26));
        c.n    = ($urandom_range(0, 19) == 0) ? 9'($urandom) : 9'($urandom_range(50, 432));
        sel    = $urandom_range(0, 3);
        c.p    = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'(2 * (sel + 1));
        c.q    = ($urandom_range(0, 29) == 0) ? 4'($urandom) : 4'($urandom_range(2, 15));
        c.ahb  = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(8, 15));
        c.apb1 = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(4, 7));
        c.apb2 = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(4, 7));
        c.ws   = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
        return c;
    endfunction

    initial
    begin
        cfg_t base;
        cfg_t c;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        allow_gaps    = 1'b1;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: a legal 168 MHz PLL setting from the crystal, then variants.
        base = '{csrc: CSRC_PLL, psrc: 2'd1, xtal: 32'd8000000, m: 8'd8, n: 9'd336,
                 p: 4'd2, q: 4'd7, ahb: 4'd0, apb1: 3'd5, apb2: 3'd4, ws: 4'd5};
        send_setting(base);
        c = base; c.csrc = CSRC_INT; c.apb1 = 3'd0; c.apb2 = 3'd0; c.ws = 4'd0;
        send_setting(c);                                   // internal oscillator
        c = base; c.csrc = CSRC_XTAL; c.xtal = 32'd26000000; c.apb1 = 3'd0; c.ws = 4'd7;
        send_setting(c);                                   // crystal at its upper edge
        c.xtal = 32'd4000000;  send_setting(c);            // crystal at its lower edge
        c.xtal = 32'd3999999;  send_setting(c);            // crystal just too slow
        c.xtal = 32'hFFFFFFFF; send_setting(c);            // crystal far too fast
        c = base; c.csrc = 2'd3; send_setting(c);          // invalid clock source
        c = base; c.psrc = 2'd2; send_setting(c);          // invalid PLL source
        c = base; c.psrc = 2'd3; send_setting(c);
        c = base; c.ahb = 4'd7; send_setting(c);           // reserved AHB code
        c = base; c.apb1 = 3'd3; send_setting(c);          // reserved APB codes
        c = base; c.apb2 = 3'd1; send_setting(c);
        c = base; c.ws = 4'd15; send_setting(c);           // wait-state code out of range
        c = base; c.ws = 4'd4; send_setting(c);            // too few wait states
        c = base; c.m = 8'd1; send_setting(c);             // divider limits
        c = base; c.m = 8'd255; send_setting(c);
        c = base; c.n = 9'd511; send_setting(c);
        c = base; c.n = 9'd0; send_setting(c);
        c = base; c.p = 4'd3; send_setting(c);
        c = base; c.q = 4'd0; send_setting(c);
        c = base; c.p = 4'd8; c.ahb = 4'd15; c.apb1 = 3'd7; c.apb2 = 3'd7; c.ws = 4'd0;
        send_setting(c);                                   // deepest prescalers
        c = base; c.apb1 = 3'd0; send_setting(c);          // APB1 too fast
        c = base; c.psrc = 2'd0; c.m = 8'd16; c.n = 9'd432; send_setting(c); // VCO top
        c = base; c.m = 8'd2; send_setting(c);             // PLL input too fast
        c = base; c.xtal = 32'd0; c.psrc = 2'd0; c.m = 8'd63; c.n = 9'd50;
        send_setting(c);                                   // VCO and PLL input too slow

        // Random part: mostly plausible settings, some fully random noise.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 200) allow_gaps = 1'b0;
            if ($urandom_range(0, 4) == 0) send_setting(any_setting());
            else                           send_setting(plausible_setting());
        end

        allow_gaps = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d results: %0d ok, %0d invalid argument, %0d out of range.",
                 verdicts_seen, status_count[0], status_count[1], status_count[2]);
        if (mismatches == 0)
            $display("clock_tree_config_checker: match");
        else
            $display("clock_tree_config_checker: mismatch");
        $finish;
    end

endmodule
